// ===== rtl/etmt_pkg.sv =====
// Package for the event timer table: payload structs, codes and constants.
// Used by every module of the block; no dependencies.
package etmt_pkg;

   localparam int NUM_TIMERS_DEF = 16;
   localparam logic [15:0] LAZY_WINDOW_RESET = 16'd300;

   typedef enum logic [2:0] {
      ACT_ADD    = 3'd0,
      ACT_DELETE = 3'd1,
      ACT_FIND   = 3'd2,
      ACT_EXPIRE = 3'd3,
      ACT_CANCEL = 3'd4
   } action_type;

   localparam logic [2:0] KIND_ACK       = 3'd0;
   localparam logic [2:0] KIND_FIND      = 3'd1;
   localparam logic [2:0] KIND_EXPIRED   = 3'd2;
   localparam logic [2:0] KIND_CANCELLED = 3'd3;
   localparam logic [2:0] KIND_DONE      = 3'd4;

   typedef struct packed {
      logic [2:0]  action;
      logic [3:0]  timer_id;
      logic [30:0] delay_ms;
      logic        is_cancelable;
      logic [31:0] now_ms;
   } req_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [3:0]  event_id;
      logic [30:0] remaining_ms;
      logic        none_armed;
      logic        last;
   } rsp_type;

   // true when a lies strictly before b on the wrapping clock
   function automatic logic earlier(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] d;
      d = a - b;
      return d[31];
   endfunction

endpackage

// ===== rtl/etmt_deadline_ram.sv =====
// Deadline store: one write port, one read port, registered read data.
// Depends on etmt_pkg only for the default of NUM_TIMERS.
module etmt_deadline_ram #(
   parameter int NUM_TIMERS = etmt_pkg::NUM_TIMERS_DEF,
   localparam int AW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [31:0]   wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [31:0]   rd_data
);
   logic [31:0] mem [NUM_TIMERS];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== rtl/event_timer_min_table.sv =====
// Event timer table: NUM_TIMERS slots of wrapping 32-bit deadlines held in a
// one-port-read synchronous RAM. Add reads the old deadline of its slot and
// then writes it; delete and unknown codes go straight to the result; find
// scans all slots, one RAM read a cycle; expire and cancel rescan after each
// emitted timer. A stalled result holds the block in its emit state. One item
// is in work at a time and the next transfer is taken in the cycle after the
// final result is loaded; the result register lets that happen while the
// result waits. Ties between equal deadlines go to the lowest slot.
module event_timer_min_table #(
   parameter int NUM_TIMERS = etmt_pkg::NUM_TIMERS_DEF,
   localparam int AW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  etmt_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output etmt_pkg::rsp_type rsp_data,
   input  logic             csr_wr_en,
   input  logic [15:0]      csr_wr_data
);
   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_RD    = 7'b0000010,
      ST_ADDWR = 7'b0000100,
      ST_SCAN  = 7'b0001000,
      ST_DEC   = 7'b0010000,
      ST_EMIT  = 7'b0100000,
      ST_WAIT  = 7'b1000000
   } state_type;

   localparam logic [AW:0] SCAN_END = (AW+1)'(NUM_TIMERS);

   state_type             state_ff, state_in;
   etmt_pkg::req_type     req_ff, req_in;
   logic [15:0]           lazy_ff, lazy_in;
   logic [NUM_TIMERS-1:0] armed_ff, armed_in, cok_ff, cok_in;
   logic [AW:0]           ptr_ff, ptr_in;     // address issued
   logic                  rdv_ff, rdv_in;     // read data valid this cycle
   logic [AW-1:0]         rda_ff, rda_in;     // address of data now on rd_data
   logic                  found_ff, found_in;
   logic [AW-1:0]         best_ff, best_in;
   logic [31:0]           bestdl_ff, bestdl_in;
   logic                  ovalid_ff, ovalid_in;
   etmt_pkg::rsp_type     out_ff, out_in;
   etmt_pkg::rsp_type     res_ff, res_in;     // result staged until the output frees
   logic                  wr_en;
   logic [AW-1:0]         wr_addr, rd_addr;
   logic [31:0]           wr_data, rd_data;
   logic                  id_ok;
   logic [31:0]           key, dk, mag, dn;
   logic                  out_free;

   etmt_deadline_ram #(.NUM_TIMERS(NUM_TIMERS)) u_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   assign out_free  = !ovalid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = ovalid_ff;
   assign rsp_data  = out_ff;
   assign id_ok     = ({28'd0, req_ff.timer_id} < 32'(NUM_TIMERS));
   assign key       = req_ff.now_ms + {1'b0, req_ff.delay_ms};
   assign dk        = key - rd_data;
   assign mag       = dk[31] ? (32'd0 - dk) : dk;
   assign dn        = bestdl_ff - req_ff.now_ms;
   assign wr_addr   = req_ff.timer_id[AW-1:0];
   assign wr_data   = key;

   always_comb begin
      state_in = state_ff; req_in = req_ff; lazy_in = lazy_ff;
      armed_in = armed_ff; cok_in = cok_ff; ptr_in = ptr_ff;
      rdv_in = 1'b0; rda_in = rda_ff; found_in = found_ff;
      best_in = best_ff; bestdl_in = bestdl_ff;
      ovalid_in = ovalid_ff && rsp_stall; out_in = out_ff; res_in = res_ff;
      wr_en = 1'b0;
      rd_addr = ptr_ff[AW-1:0];
      if (csr_wr_en) lazy_in = csr_wr_data;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in = req_data;
               ptr_in = '0;
               found_in = 1'b0;
               state_in = ST_RD;
            end
         end
         ST_RD: begin
            unique case (req_ff.action) inside
               etmt_pkg::ACT_ADD: begin
                  rd_addr = req_ff.timer_id[AW-1:0];
                  state_in = ST_ADDWR;
               end
               etmt_pkg::ACT_FIND, etmt_pkg::ACT_EXPIRE, etmt_pkg::ACT_CANCEL: begin
                  ptr_in = '0; found_in = 1'b0;
                  state_in = ST_SCAN;
               end
               default: begin
                  if (req_ff.action == etmt_pkg::ACT_DELETE && id_ok)
                     armed_in[req_ff.timer_id[AW-1:0]] = 1'b0;
                  res_in = '{kind: etmt_pkg::KIND_ACK, event_id: '0,
                             remaining_ms: '0, none_armed: 1'b0, last: 1'b1};
                  state_in = ST_EMIT;
               end
            endcase
         end
         ST_ADDWR: begin
            if (id_ok) begin
               // lazy keep: armed and |new-old| below window (-2^31 never kept)
               if (!(armed_ff[wr_addr] && !(dk == 32'h8000_0000)
                     && mag < {16'd0, lazy_ff}))
                  wr_en = 1'b1;
               armed_in[wr_addr] = 1'b1;
               cok_in[wr_addr] = req_ff.is_cancelable;
            end
            res_in = '{kind: etmt_pkg::KIND_ACK, event_id: '0,
                       remaining_ms: '0, none_armed: 1'b0, last: 1'b1};
            state_in = ST_EMIT;
         end
         ST_SCAN: begin
            if (ptr_ff != SCAN_END) begin
               rdv_in = 1'b1;
               rda_in = ptr_ff[AW-1:0];
               ptr_in = ptr_ff + 1'b1;
            end
            if (rdv_ff && armed_ff[rda_ff]
                && (!found_ff || etmt_pkg::earlier(rd_data, bestdl_ff))) begin
               found_in = 1'b1; best_in = rda_ff; bestdl_in = rd_data;
            end
            if (ptr_ff == SCAN_END && !rdv_ff) state_in = ST_DEC;
         end
         ST_DEC: begin
            res_in = '{kind: etmt_pkg::KIND_DONE, event_id: '0,
                       remaining_ms: '0, none_armed: 1'b0, last: 1'b1};
            state_in = ST_EMIT;
            if (req_ff.action == etmt_pkg::ACT_FIND) begin
               res_in.kind = etmt_pkg::KIND_FIND;
               res_in.none_armed = !found_ff;
               res_in.remaining_ms = (found_ff && !dn[31]) ? dn[30:0] : '0;
            end else if (found_ff &&
                  ((req_ff.action == etmt_pkg::ACT_EXPIRE && (dn == 32'd0 || dn[31]))
                || (req_ff.action == etmt_pkg::ACT_CANCEL && cok_ff[best_ff]))) begin
               armed_in[best_ff] = 1'b0;
               res_in.kind = (req_ff.action == etmt_pkg::ACT_EXPIRE)
                             ? etmt_pkg::KIND_EXPIRED : etmt_pkg::KIND_CANCELLED;
               res_in.event_id = 4'(best_ff);
               res_in.last = 1'b0;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               ovalid_in = 1'b1;
               out_in = res_ff;
               ptr_in = '0; found_in = 1'b0;
               state_in = res_ff.last ? ST_IDLE : ST_WAIT;
            end
         end
         ST_WAIT: state_in = ST_SCAN;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; lazy_ff <= etmt_pkg::LAZY_WINDOW_RESET;
         armed_ff <= '0; cok_ff <= '0; ovalid_ff <= 1'b0; rdv_ff <= 1'b0;
         ptr_ff <= '0; found_ff <= 1'b0;
      end else begin
         state_ff <= state_in; lazy_ff <= lazy_in;
         armed_ff <= armed_in; cok_ff <= cok_in; ovalid_ff <= ovalid_in;
         rdv_ff <= rdv_in; ptr_ff <= ptr_in; found_ff <= found_in;
      end
      req_ff <= req_in; rda_ff <= rda_in; best_ff <= best_in;
      bestdl_ff <= bestdl_in; out_ff <= out_in; res_ff <= res_in;
   end

`ifndef NO_ASSERTIONS
   a_busy_stall: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> req_stall) else $error("accepted while busy");
   a_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff)) else $error("state not one-hot");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");
`endif
endmodule
